@@ rtl/ffvs_pkg.sv @@
// ----------------------------------------------------------------------------
// ffvs_pkg
// Shared types and constants of the flicker frequency vote and stabiliser.
// ----------------------------------------------------------------------------
package ffvs_pkg;

    localparam int unsigned QShift   = 10;
    localparam int unsigned MaxModes = 2;
    localparam int unsigned RemW     = 17;  // 16 * 4095 fits in 17 bits

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_WEAK     = 3'd1,
        ST_SECOND   = 3'd2,
        ST_NO_BOX   = 3'd3,
        ST_SHORT    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        REG_AMP_THR    = 3'd0,
        REG_RATIO      = 3'd1,
        REG_DELTA      = 3'd2,
        REG_COUNT_THR  = 3'd3,
        REG_CLOSE      = 3'd4,
        REG_BOX_FIRST  = 3'd5,
        REG_BOX_SECOND = 3'd6,
        REG_NONE       = 3'd7
    } t_reg_idx;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, start checks
        logic div_start;  // start remainder for current box
        logic div_step;   // one remainder bit
        logic box_eval;   // compare distance of current box
        logic box_next;   // advance box index
        logic commit;     // update window and flags
        logic show;       // load output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic last_box;
    } t_sts;

endpackage

@@ rtl/flicker_frequency_vote_and_stabilize.sv @@
// ----------------------------------------------------------------------------
// flicker_frequency_vote_and_stabilize
// Vets flicker spectrum requests, votes a mains mode and stabilises it.
// ----------------------------------------------------------------------------
// One request at a time. Each box runs setup, 16 steps of the
// bit-serial remainder of the 16-bit frequency against the box span, a check
// that the remainder is done and a compare of the distance. Commit and result
// load follow, and a new request is taken only once the result is loaded,
// which waits while the output is stalled. The next request may enter while
// the previous result still waits on the output.
module flicker_frequency_vote_and_stabilize #(
    parameter int unsigned WINDOW_DEPTH = 8,
    parameter int unsigned NUM_BOXES    = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_peak_amp,
    input  logic [31:0] i_second_amp,
    input  logic [15:0] i_peak_frequency,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [1:0]  o_item_mode,
    output logic [1:0]  o_stable_mode,
    output logic [1:0]  o_reported_mode,
    output logic        o_stats_enable,
    output logic        o_banding_seen,
    output logic        o_sensor_off,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_amp_thr;
    logic [11:0] r_ratio;
    logic [15:0] r_delta;
    logic [7:0]  r_cnt_thr;
    logic        r_close;
    logic [11:0] r_box1, r_box2;
    ffvs_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_idx  = ffvs_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp_thr <= 16'd0;
            r_ratio   <= 12'd614;
            r_delta   <= 16'd0;
            r_cnt_thr <= 8'd5;
            r_close   <= 1'b0;
            r_box1    <= 12'd50;
            r_box2    <= 12'd60;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (w_idx)
                ffvs_pkg::REG_AMP_THR:    r_amp_thr <= pwdata[15:0];
                ffvs_pkg::REG_RATIO:      r_ratio   <= pwdata[11:0];
                ffvs_pkg::REG_DELTA:      r_delta   <= pwdata[15:0];
                ffvs_pkg::REG_COUNT_THR:  r_cnt_thr <= pwdata[7:0];
                ffvs_pkg::REG_CLOSE:      r_close   <= pwdata[0];
                ffvs_pkg::REG_BOX_FIRST:  r_box1    <= pwdata[11:0];
                ffvs_pkg::REG_BOX_SECOND: r_box2    <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            ffvs_pkg::REG_AMP_THR:    prdata = {16'd0, r_amp_thr};
            ffvs_pkg::REG_RATIO:      prdata = {20'd0, r_ratio};
            ffvs_pkg::REG_DELTA:      prdata = {16'd0, r_delta};
            ffvs_pkg::REG_COUNT_THR:  prdata = {24'd0, r_cnt_thr};
            ffvs_pkg::REG_CLOSE:      prdata = {31'd0, r_close};
            ffvs_pkg::REG_BOX_FIRST:  prdata = {20'd0, r_box1};
            ffvs_pkg::REG_BOX_SECOND: prdata = {20'd0, r_box2};
            default:                  prdata = 32'd0;
        endcase
    end

    ffvs_pkg::t_cmd w_cmd;
    ffvs_pkg::t_sts w_sts;

    ffvs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    ffvs_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .NUM_BOXES    (NUM_BOXES)
    ) u_dp (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cmd                    (w_cmd),
        .o_sts                    (w_sts),
        .i_peak_amp               (i_peak_amp),
        .i_second_amp             (i_second_amp),
        .i_peak_frequency         (i_peak_frequency),
        .i_amp_threshold          (r_amp_thr),
        .i_second_peak_ratio      (r_ratio),
        .i_vote_delta_limit       (r_delta),
        .i_stable_count_threshold (r_cnt_thr),
        .i_close_after_change     (r_close),
        .i_box_freq_first         (r_box1),
        .i_box_freq_second        (r_box2),
        .o_status                 (o_status),
        .o_item_mode              (o_item_mode),
        .o_stable_mode            (o_stable_mode),
        .o_reported_mode          (o_reported_mode),
        .o_stats_enable           (o_stats_enable),
        .o_banding_seen           (o_banding_seen),
        .o_sensor_off             (o_sensor_off)
    );

endmodule

@@ rtl/ffvs_datapath.sv @@
// ----------------------------------------------------------------------------
// ffvs_datapath
// Amplitude checks, serial remainder per box, window and majority vote.
// ----------------------------------------------------------------------------
module ffvs_datapath #(
    parameter int unsigned WINDOW_DEPTH = 8,
    parameter int unsigned NUM_BOXES    = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ffvs_pkg::t_cmd       i_cmd,
    output ffvs_pkg::t_sts       o_sts,
    input  logic [31:0]          i_peak_amp,
    input  logic [31:0]          i_second_amp,
    input  logic [15:0]          i_peak_frequency,
    input  logic [15:0]          i_amp_threshold,
    input  logic [11:0]          i_second_peak_ratio,
    input  logic [15:0]          i_vote_delta_limit,
    input  logic [7:0]           i_stable_count_threshold,
    input  logic                 i_close_after_change,
    input  logic [11:0]          i_box_freq_first,
    input  logic [11:0]          i_box_freq_second,
    output logic [2:0]           o_status,
    output logic [1:0]           o_item_mode,
    output logic [1:0]           o_stable_mode,
    output logic [1:0]           o_reported_mode,
    output logic                 o_stats_enable,
    output logic                 o_banding_seen,
    output logic                 o_sensor_off
);

    localparam int unsigned PtrW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned CntW   = $clog2(WINDOW_DEPTH + 1);
    localparam int unsigned NbEff  = (NUM_BOXES < ffvs_pkg::MaxModes) ?
                                     NUM_BOXES : ffvs_pkg::MaxModes;
    localparam int unsigned RemW   = ffvs_pkg::RemW;

    // request capture and amplitude checks
    logic [15:0] r_freq;
    ffvs_pkg::t_status r_fail;  // ok, weak or second high
    logic [31:0] n_thr_sq;
    logic [43:0] n_prod;

    assign n_thr_sq = i_amp_threshold * i_amp_threshold;
    assign n_prod   = i_peak_amp * i_second_peak_ratio;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_freq   <= i_peak_frequency;
            if (i_peak_amp < n_thr_sq) begin
                r_fail <= ffvs_pkg::ST_WEAK;
            end else if (i_second_amp > n_prod[43:ffvs_pkg::QShift]) begin
                r_fail <= ffvs_pkg::ST_SECOND;
            end else begin
                r_fail <= ffvs_pkg::ST_OK;
            end
        end
    end

    // serial remainder freq16 mod span, one bit per cycle
    logic          r_box;
    logic [RemW-1:0] r_rem;
    logic [4:0]    r_bit;
    logic [11:0]   w_base;
    logic [RemW-1:0] w_span;
    logic [RemW:0]   w_trial;

    assign w_base  = r_box ? i_box_freq_second : i_box_freq_first;
    assign w_span  = {1'b0, w_base, 4'b0000};
    assign w_trial = {r_rem, r_freq[r_bit[3:0]]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_bit <= 5'd15;
        end else if (i_cmd.div_step) begin
            if (w_trial >= {1'b0, w_span}) begin
                r_rem <= RemW'(w_trial - {1'b0, w_span});
            end else begin
                r_rem <= w_trial[RemW-1:0];
            end
            r_bit <= r_bit - 5'd1;
        end
    end

    assign o_sts.div_done = r_bit[4];
    assign o_sts.last_box = (32'(r_box) + 32'd1 >= NbEff);

    // box distance compare
    logic [15:0] r_best;
    logic [1:0]  r_mode;
    logic [RemW-1:0] w_up;
    logic [12:0] w_d0, w_d1, w_d;

    assign w_up = w_span - r_rem;
    assign w_d0 = r_rem[RemW-1:4];
    assign w_d1 = w_up[RemW-1:4];
    assign w_d  = (w_d0 < w_d1) ? w_d0 : w_d1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_box  <= 1'b0;
            r_best <= i_vote_delta_limit;
            r_mode <= 2'd0;
        end else begin
            if (i_cmd.box_eval && (w_base != 12'd0) && ({3'b000, w_d} < r_best)) begin
                r_best <= {3'b000, w_d};
                r_mode <= {1'b0, r_box} + 2'd1;
            end
            if (i_cmd.box_next) begin
                r_box <= 1'b1;
            end
        end
    end

    // window and counts
    logic [1:0]      r_win [WINDOW_DEPTH];
    logic [PtrW-1:0] r_ptr;
    logic [CntW-1:0] r_cnt1, r_cnt2;
    logic [1:0]      r_held;
    logic            r_stats, r_band, r_off;

    logic [PtrW-1:0] w_nptr;
    logic [1:0]      w_leave;
    logic [CntW-1:0] w_c1, w_c2, w_bcnt;
    logic [1:0]      w_bmode;
    logic            w_stable;

    always_comb begin
        w_nptr = (32'(r_ptr) + 32'd1 >= WINDOW_DEPTH) ? '0 : PtrW'(r_ptr + 1'b1);
        // entry under the new pointer; itself if depth wraps onto the write slot
        w_leave = (w_nptr == r_ptr) ? r_mode : r_win[w_nptr];
        w_c1 = r_cnt1 + CntW'(r_mode == 2'd1);
        w_c2 = r_cnt2 + CntW'(r_mode == 2'd2);
        if (w_leave == 2'd1 && w_c1 != '0) begin
            w_c1 = w_c1 - 1'b1;
        end
        if (w_leave == 2'd2 && w_c2 != '0) begin
            w_c2 = w_c2 - 1'b1;
        end
        if (w_c2 > w_c1) begin
            w_bmode = 2'd2;
            w_bcnt  = w_c2;
        end else begin
            w_bmode = 2'd1;
            w_bcnt  = w_c1;
        end
        w_stable = (32'(w_bcnt) >= 32'(i_stable_count_threshold));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_win[i] <= 2'd0;
            end
            r_ptr   <= '0;
            r_cnt1  <= '0;
            r_cnt2  <= '0;
            r_held  <= 2'd0;
            r_stats <= 1'b1;
            r_band  <= 1'b0;
            r_off   <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_fail != ffvs_pkg::ST_OK) begin
                r_stats <= 1'b1;
            end else begin
                r_band <= 1'b1;
                if (r_mode == 2'd0) begin
                    r_stats <= 1'b1;
                end else begin
                    r_win[r_ptr] <= r_mode;
                    r_ptr        <= w_nptr;
                    r_cnt1       <= w_c1;
                    r_cnt2       <= w_c2;
                    if (w_stable) begin
                        r_stats <= 1'b0;
                        r_held  <= w_bmode;
                        if (i_close_after_change) begin
                            r_off <= 1'b1;
                            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                                r_win[i] <= 2'd0;
                            end
                            r_cnt1 <= '0;
                            r_cnt2 <= '0;
                        end
                    end else begin
                        r_stats <= 1'b1;
                    end
                end
            end
        end
    end

    // result register, loaded together with the window update on commit
    logic [2:0] r_status;
    logic [1:0] r_item, r_stab;
    logic       r_was_stable;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_fail == ffvs_pkg::ST_WEAK) begin
                r_status <= ffvs_pkg::ST_WEAK;
            end else if (r_fail == ffvs_pkg::ST_SECOND) begin
                r_status <= ffvs_pkg::ST_SECOND;
            end else if (r_mode == 2'd0) begin
                r_status <= ffvs_pkg::ST_NO_BOX;
            end else if (w_stable) begin
                r_status <= ffvs_pkg::ST_OK;
            end else begin
                r_status <= ffvs_pkg::ST_SHORT;
            end
            r_item       <= (r_fail == ffvs_pkg::ST_OK) ? r_mode : 2'd0;
            r_stab       <= w_bmode;
            r_was_stable <= (r_fail == ffvs_pkg::ST_OK) && (r_mode != 2'd0) && w_stable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.show) begin
            o_status        <= r_status;
            o_item_mode     <= r_item;
            o_stable_mode   <= r_was_stable ? r_stab : 2'd0;
            o_reported_mode <= r_held;
            o_stats_enable  <= r_stats;
            o_banding_seen  <= r_band;
            o_sensor_off    <= r_off;
        end
    end

endmodule

@@ rtl/ffvs_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffvs_ctrl
// Sequencer: accept request, run box remainders, commit, present result.
// ----------------------------------------------------------------------------
module ffvs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    output ffvs_pkg::t_cmd o_cmd,
    input  ffvs_pkg::t_sts i_sts
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_START  = 6'b000010,
        S_DIV    = 6'b000100,
        S_EVAL   = 6'b001000,
        S_COMMIT = 6'b010000,
        S_SHOW   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;
    logic   w_take, w_out_free;

    assign w_out_free = !r_ovalid || !i_stall;
    assign o_stall    = (r_state != S_IDLE);
    assign w_take     = (r_state == S_IDLE) && i_valid;
    assign o_valid    = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && i_stall;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_EVAL;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_EVAL: begin
                o_cmd.box_eval = 1'b1;
                if (i_sts.last_box) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.box_next = 1'b1;
                    n_state        = S_START;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_SHOW;
            end
            S_SHOW: begin
                if (w_out_free) begin
                    o_cmd.show = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

@@ tb/flicker_frequency_vote_and_stabilize_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flicker_frequency_vote_and_stabilize_tb
// Drives spectrum requests with random gaps and output stalls, predicts the
// vote, window majority and sticky flags per request, and checks each result.
// ----------------------------------------------------------------------------
module flicker_frequency_vote_and_stabilize_tb;

    typedef struct packed {
        logic [31:0] peak;
        logic [31:0] second;
        logic [15:0] freq;
    } t_spectrum;

    typedef struct packed {
        logic [2:0] status;
        logic [1:0] item_mode;
        logic [1:0] stable_mode;
        logic [1:0] reported_mode;
        logic       stats;
        logic       banding;
        logic       off;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_peak_amp;
    logic [31:0] i_second_amp;
    logic [15:0] i_peak_frequency;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [1:0]  o_item_mode;
    logic [1:0]  o_stable_mode;
    logic [1:0]  o_reported_mode;
    logic        o_stats_enable;
    logic        o_banding_seen;
    logic        o_sensor_off;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    flicker_frequency_vote_and_stabilize i_dut (.*);

    // predictor state and configuration
    logic [15:0] amp_thr;
    logic [11:0] ratio;
    logic [15:0] delta_lim;
    logic [7:0]  count_thr;
    logic        close_chg;
    logic [11:0] box_f [2];
    logic [1:0]  win [8];
    logic [2:0]  win_ptr;
    int unsigned mcount [3];
    logic [1:0]  held;
    logic        stats_f, band_f, off_f;

    t_spectrum pending_q [$];
    t_verdict  verdict_q [$];
    int  errors = 0;
    int  drv_gap = 0;
    int  rx_gap = 0;
    int  hold_rx = 0;
    bit  quiet = 0;
    bit  done = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [1:0] harmonic_vote(input logic [15:0] f);
        int unsigned best, span, r, d0, d1, d;
        logic [1:0] m;
        best = delta_lim;
        m = 0;
        for (int i = 0; i < 2; i++) begin
            if (box_f[i] != 0) begin
                span = box_f[i] * 16;
                r = f % span;
                d0 = r >> 4;
                d1 = (span - r) >> 4;
                d = d0 < d1 ? d0 : d1;
                if (d < best) begin
                    best = d;
                    m = 2'(i + 1);
                end
            end
        end
        return m;
    endfunction

    function automatic t_verdict judge_spectrum(input t_spectrum s);
        t_verdict v;
        logic [1:0] leaving, best_m;
        int unsigned best_c;
        logic [63:0] prod;
        v = '0;
        prod = 64'(s.peak) * 64'(ratio);
        if (64'(s.peak) < 64'(amp_thr) * 64'(amp_thr)) begin
            v.status = ffvs_pkg::ST_WEAK;
            stats_f = 1;
        end else if (64'(s.second) > (prod >> ffvs_pkg::QShift)) begin
            v.status = ffvs_pkg::ST_SECOND;
            stats_f = 1;
        end else begin
            band_f = 1;
            v.item_mode = harmonic_vote(s.freq);
            if (v.item_mode == 0) begin
                v.status = ffvs_pkg::ST_NO_BOX;
                stats_f = 1;
            end else begin
                win[win_ptr] = v.item_mode;
                mcount[v.item_mode]++;
                win_ptr = win_ptr + 3'd1;
                leaving = win[win_ptr];
                if (leaving != 0 && mcount[leaving] > 0) mcount[leaving]--;
                best_m = 1;
                best_c = mcount[1];
                if (mcount[2] > best_c) begin
                    best_c = mcount[2];
                    best_m = 2;
                end
                if (best_c >= count_thr) begin
                    v.status = ffvs_pkg::ST_OK;
                    v.stable_mode = best_m;
                    stats_f = 0;
                    held = best_m;
                    if (close_chg) begin
                        off_f = 1;
                        foreach (win[k]) win[k] = 0;
                        foreach (mcount[k]) mcount[k] = 0;
                    end
                end else begin
                    v.status = ffvs_pkg::ST_SHORT;
                    stats_f = 1;
                end
            end
        end
        v.reported_mode = held;
        v.stats = stats_f;
        v.banding = band_f;
        v.off = off_f;
        return v;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                verdict_q.push_back(judge_spectrum(
                    {i_peak_amp, i_second_amp, i_peak_frequency}));
            end
            if (!i_valid || !o_stall) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    i_valid <= 0;
                end else if (pending_q.size() > 0) begin
                    t_spectrum s;
                    s = pending_q.pop_front();
                    i_valid <= 1;
                    i_peak_amp <= s.peak;
                    i_second_amp <= s.second;
                    i_peak_frequency <= s.freq;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        drv_gap <= $urandom_range(1, 17);
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // result monitor and output stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result status=%0d", $time, o_status);
                    errors++;
                end else begin
                    t_verdict e, a;
                    e = verdict_q.pop_front();
                    a = {o_status, o_item_mode, o_stable_mode, o_reported_mode,
                         o_stats_enable, o_banding_seen, o_sensor_off};
                    if (a !== e) begin
                        $display("%0t: mismatch expected st=%0d im=%0d sm=%0d rm=%0d",
                                 $time, e.status, e.item_mode, e.stable_mode,
                                 e.reported_mode, " se=%0d bs=%0d so=%0d",
                                 e.stats, e.banding, e.off);
                        $display("%0t:          actual st=%0d im=%0d sm=%0d rm=%0d",
                                 $time, a.status, a.item_mode, a.stable_mode,
                                 a.reported_mode, " se=%0d bs=%0d so=%0d",
                                 a.stats, a.banding, a.off);
                        errors++;
                    end
                end
            end
            if (hold_rx > 0) begin
                hold_rx <= hold_rx - 1;
                i_stall <= 1;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_stall <= 1;
            end else begin
                i_stall <= 0;
                if (!quiet && $urandom_range(0, 9) == 0) rx_gap <= $urandom_range(1, 17);
            end
        end
    end

    task automatic apb_write(input ffvs_pkg::t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            ffvs_pkg::REG_AMP_THR:    amp_thr = val[15:0];
            ffvs_pkg::REG_RATIO:      ratio = val[11:0];
            ffvs_pkg::REG_DELTA:      delta_lim = val[15:0];
            ffvs_pkg::REG_COUNT_THR:  count_thr = val[7:0];
            ffvs_pkg::REG_CLOSE:      close_chg = val[0];
            ffvs_pkg::REG_BOX_FIRST:  box_f[0] = val[11:0];
            ffvs_pkg::REG_BOX_SECOND: box_f[1] = val[11:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_q.size() == 0);
        // let the last popped request reach the port before checking idle
        @(posedge i_clk);
        wait (!i_valid && verdict_q.size() == 0);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic t_spectrum make_spectrum(input bit shaped);
        t_spectrum s;
        int unsigned b, k;
        s.peak = $urandom;
        s.second = $urandom;
        s.freq = $urandom;
        if (shaped) begin
            // pass amplitude tests most of the time, land near a harmonic
            s.peak = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1 << 20, 32'hFFFF_FFFF);
            s.second = $urandom_range(0, 7) == 0 ? $urandom : s.peak >> $urandom_range(2, 12);
            b = box_f[$urandom_range(0, 1)];
            if (b != 0) begin
                k = $urandom_range(1, 65535 / (16 * b) + 1);
                s.freq = 16'(k * 16 * b + $urandom_range(0, 63) - 32);
            end
        end
        return s;
    endfunction

    task automatic random_phase(input int n, input int shaped_pct);
        for (int i = 0; i < n; i++)
            pending_q.push_back(make_spectrum($urandom_range(1, 100) <= shaped_pct));
    endtask

    initial begin
        i_rst_n = 0; i_valid = 0; i_stall = 0;
        i_peak_amp = 0; i_second_amp = 0; i_peak_frequency = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        amp_thr = 0; ratio = 614; delta_lim = 0; count_thr = 5; close_chg = 0;
        box_f[0] = 50; box_f[1] = 60;
        foreach (win[k]) win[k] = 0;
        foreach (mcount[k]) mcount[k] = 0;
        win_ptr = 0; held = 0; stats_f = 1; band_f = 0; off_f = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: reset settings reject everything, at the second-peak check or at the box vote
        pending_q.push_back('{32'd0, 32'd0, 16'd0});
        pending_q.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF});
        pending_q.push_back('{32'hFFFF_FFFF, 32'd0, 16'd800});
        drain();
        apb_write(ffvs_pkg::REG_AMP_THR, 32'hFFFF);
        apb_write(ffvs_pkg::REG_DELTA, 32'd3);
        apb_write(ffvs_pkg::REG_COUNT_THR, 32'd3);
        pending_q.push_back('{32'hFFFE_0000, 32'd0, 16'd800});   // weak
        pending_q.push_back('{32'hFFFE_0001, 32'hFFFF_FFFF, 16'd800}); // second high
        pending_q.push_back('{32'hFFFF_FFFF, 32'd0, 16'd1360});   // 85 Hz: no box
        pending_q.push_back('{32'hFFFF_FFFF, 32'd0, 16'd1600});   // 100 Hz: box 1
        pending_q.push_back('{32'hFFFF_FFFF, 32'd0, 16'd1920});   // 120 Hz: box 2
        pending_q.push_back('{32'hFFFF_FFFF, 32'd0, 16'd1632});   // 102 Hz, box 1
        pending_q.push_back('{32'hFFFF_FFFF, 32'd0, 16'd1600});   // stable now
        drain();
        // equal distance to both boxes: first box wins; zero box never matches
        apb_write(ffvs_pkg::REG_BOX_FIRST, 32'd10);
        apb_write(ffvs_pkg::REG_BOX_SECOND, 32'd12);
        apb_write(ffvs_pkg::REG_CLOSE, 32'd1);
        apb_write(ffvs_pkg::REG_COUNT_THR, 32'd0);
        pending_q.push_back('{32'hFFFF_FFFF, 32'd0, 16'd176});    // 11 Hz tie
        pending_q.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd176});
        drain();
        apb_write(ffvs_pkg::REG_BOX_FIRST, 32'd0);
        apb_write(ffvs_pkg::REG_BOX_SECOND, 32'hFFF);
        apb_write(ffvs_pkg::REG_RATIO, 32'hFFF);
        apb_write(ffvs_pkg::REG_DELTA, 32'hFFFF);
        pending_q.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0});
        pending_q.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF});
        drain();

        // random phases across settings
        apb_write(ffvs_pkg::REG_AMP_THR, 32'd0);
        apb_write(ffvs_pkg::REG_RATIO, 32'd614);
        apb_write(ffvs_pkg::REG_DELTA, 32'd4);
        apb_write(ffvs_pkg::REG_COUNT_THR, 32'd5);
        apb_write(ffvs_pkg::REG_CLOSE, 32'd0);
        apb_write(ffvs_pkg::REG_BOX_FIRST, 32'd50);
        apb_write(ffvs_pkg::REG_BOX_SECOND, 32'd60);
        random_phase(400, 80);
        // long output hold-off so the block backs up
        hold_rx = 300;
        drain();
        apb_write(ffvs_pkg::REG_AMP_THR, $urandom_range(0, 3000));
        apb_write(ffvs_pkg::REG_RATIO, $urandom_range(0, 4095));
        apb_write(ffvs_pkg::REG_DELTA, $urandom_range(1, 20));
        apb_write(ffvs_pkg::REG_COUNT_THR, $urandom_range(1, 8));
        apb_write(ffvs_pkg::REG_CLOSE, 32'd1);
        apb_write(ffvs_pkg::REG_BOX_FIRST, $urandom_range(1, 4095));
        apb_write(ffvs_pkg::REG_BOX_SECOND, $urandom_range(1, 200));
        random_phase(400, 80);
        drain();
        apb_write(ffvs_pkg::REG_AMP_THR, 32'd0);
        apb_write(ffvs_pkg::REG_RATIO, 32'hFFF);
        apb_write(ffvs_pkg::REG_DELTA, 32'hFFFF);
        apb_write(ffvs_pkg::REG_COUNT_THR, 32'hFF);
        apb_write(ffvs_pkg::REG_CLOSE, 32'd0);
        random_phase(300, 50);
        drain();
        for (int p = 0; p < 3; p++) begin
            apb_write(ffvs_pkg::REG_AMP_THR, $urandom_range(0, 65535));
            apb_write(ffvs_pkg::REG_RATIO, $urandom_range(400, 4095));
            apb_write(ffvs_pkg::REG_DELTA, $urandom_range(0, 40));
            apb_write(ffvs_pkg::REG_COUNT_THR, $urandom_range(0, 9));
            apb_write(ffvs_pkg::REG_CLOSE, $urandom_range(0, 1));
            apb_write(ffvs_pkg::REG_BOX_FIRST, $urandom_range(1, 120));
            apb_write(ffvs_pkg::REG_BOX_SECOND, $urandom_range(0, 4095));
            if (p == 2) quiet = 1;
            random_phase(300, 85);
            drain();
        end
        done = 1;
    end

    initial begin
        wait (done);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
